>>> sv/circular_deque_top_macros.svh
// Assertion macros for the circular deque top level.
`ifndef CIRCULAR_DEQUE_TOP_MACROS_SVH
`define CIRCULAR_DEQUE_TOP_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define CDQ_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define CDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/cdq_pkg.sv
// Shared constants, operation codes and cell control type for the circular deque.
`timescale 1ns / 1ps

package cdq_pkg;

  localparam int DEF_MAX_DEPTH  = 16;
  localparam int DEF_VALUE_BITS = 32;

  localparam int CAP_BITS  = 5;
  localparam int CAP_RESET = 16;

  localparam int MODE_BITS = 3;
  localparam logic [MODE_BITS-1:0] MODE_NONE       = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_PUSH_FRONT = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_PUSH_REAR  = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_POP_FRONT  = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_POP_REAR   = 3'd4;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_CAPACITY = 2'd0;

  // One-hot (or all-zero) command broadcast to every cell.
  typedef struct packed {
    logic clear;
    logic push_front;
    logic push_rear;
    logic pop_front;
    logic pop_rear;
  } cell_ctl_t;

endpackage

>>> sv/cdq_cell.sv
// One deque cell: holds one value and its occupied flag, shifts with its neighbors.
`timescale 1ns / 1ps

module cdq_cell #(
  parameter int VALUE_BITS = cdq_pkg::DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cdq_pkg::cell_ctl_t    ctl,
  input  logic [VALUE_BITS-1:0] push_val,
  input  logic [VALUE_BITS-1:0] left_val,
  input  logic                  left_vld,
  input  logic [VALUE_BITS-1:0] right_val,
  input  logic                  right_vld,
  output logic [VALUE_BITS-1:0] val_o,
  output logic                  vld_o,
  output logic [VALUE_BITS-1:0] val_nxt_o,
  output logic                  vld_nxt_o
);

  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic                  vld_r, vld_nxt;

  always_comb begin
    val_nxt = val_r;
    vld_nxt = vld_r;
    if (ctl.clear) begin
      vld_nxt = 1'b0;
    end else if (ctl.push_front) begin
      val_nxt = left_val;
      vld_nxt = left_vld;
    end else if (ctl.push_rear) begin
      // first free slot takes the value
      if (!vld_r && left_vld) begin
        val_nxt = push_val;
        vld_nxt = 1'b1;
      end
    end else if (ctl.pop_front) begin
      val_nxt = right_val;
      vld_nxt = right_vld;
    end else if (ctl.pop_rear) begin
      // last occupied slot drops out
      if (vld_r && !right_vld) begin
        vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val_o     = val_r;
  assign vld_o     = vld_r;
  assign val_nxt_o = val_nxt;
  assign vld_nxt_o = vld_nxt;

endmodule

>>> sv/circular_deque_top.sv
// Top level of the circular deque: cell row, capacity register, item handshake.
`timescale 1ns / 1ps
// Double-ended queue with a programmable capacity (1..MAX_DEPTH entries).
// Input channel in_*: tdata = {pad, value, mode}; mode 0 none, 1 push front,
//   2 push rear, 3 pop front, 4 pop rear (5..7 act as none).
// Output channel out_*: one item per input item with accepted, front value,
//   rear value (both -1 when empty), is_empty and is_full, all after the operation.
// Config port cfg_* (APB-like): capacity at byte address 0; a write keeps the
//   low five bits (clipped to 1..MAX_DEPTH in use) and empties the deque.
// Storage is a row of cells with the front in cell 0; a front push or pop shifts the
//   whole row by one cell, a rear push or pop changes only the end cell; no pointer math.
// The result is registered: the output register loads it when the input item is taken.
// Throughput: one item per cycle unless the output stalls; the cell row updates in
//   the cycle an item is taken and the output register is loaded from the cells' next values.
// Reset: capacity 16, deque empty, output register empty.
// Stall: if out_tready is low while a result is held, in_tready drops and
//   the held result stays until it is taken; no item is lost or repeated.
`include "circular_deque_top_macros.svh"

module circular_deque_top #(
  parameter  int MAX_DEPTH  = cdq_pkg::DEF_MAX_DEPTH,
  parameter  int VALUE_BITS = cdq_pkg::DEF_VALUE_BITS,
  // stream widths, padded to whole bytes
  localparam int IN_W       = ((cdq_pkg::MODE_BITS + VALUE_BITS + 7) / 8) * 8,
  localparam int OUT_W      = ((3 + 2 * VALUE_BITS + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: mode[2:0], value[VALUE_BITS+2:3], zero pad
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [IN_W-1:0]                in_tdata,
  // out_tdata: accepted, front_value, rear_value, is_empty, is_full, zero pad
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [OUT_W-1:0]               out_tdata,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [cdq_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [cdq_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [cdq_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  localparam int CNT_W   = $clog2(MAX_DEPTH + 1);
  localparam int CW      = (CNT_W > cdq_pkg::CAP_BITS) ? CNT_W : cdq_pkg::CAP_BITS;

  // ---------------- configuration ----------------
  logic [cdq_pkg::CAP_BITS-1:0] cap_raw_r;
  logic [CW-1:0]                cap_ext, cap_eff;
  logic                         cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr == cdq_pkg::REG_CAPACITY);
  assign cfg_prdata = (cfg_paddr == cdq_pkg::REG_CAPACITY) ?
                      cdq_pkg::CFG_DATA_W'(cap_raw_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_raw_r <= cdq_pkg::CAP_BITS'(cdq_pkg::CAP_RESET);
    end else if (cfg_wr) begin
      cap_raw_r <= cfg_pwdata[cdq_pkg::CAP_BITS-1:0];
    end
  end

  // capacity 0 acts as 1, above MAX_DEPTH acts as MAX_DEPTH
  assign cap_ext = CW'(cap_raw_r);
  assign cap_eff = (cap_ext == '0) ? CW'(1) :
                   (cap_ext > CW'(MAX_DEPTH)) ? CW'(MAX_DEPTH) : cap_ext;

  // ---------------- input decode ----------------
  logic [cdq_pkg::MODE_BITS-1:0] mode;
  logic [VALUE_BITS-1:0]         value;
  logic                          in_fire;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic                          full, empty;
  logic                          accepted;
  cdq_pkg::cell_ctl_t            ctl;

  assign mode    = in_tdata[cdq_pkg::MODE_BITS-1:0];
  assign value   = in_tdata[cdq_pkg::MODE_BITS +: VALUE_BITS];
  assign in_fire = in_tvalid && in_tready;
  assign full    = CW'(count_r) >= cap_eff;
  assign empty   = (count_r == '0);

  always_comb begin
    ctl       = '0;
    accepted  = 1'b1;
    count_nxt = count_r;
    if (cfg_wr) begin
      ctl.clear = 1'b1;
      count_nxt = '0;
    end else if (in_fire) begin
      case (mode)
        cdq_pkg::MODE_PUSH_FRONT, cdq_pkg::MODE_PUSH_REAR: begin
          if (full) begin
            accepted = 1'b0;
          end else begin
            ctl.push_front = (mode == cdq_pkg::MODE_PUSH_FRONT);
            ctl.push_rear  = (mode == cdq_pkg::MODE_PUSH_REAR);
            count_nxt      = count_r + CNT_W'(1);
          end
        end
        cdq_pkg::MODE_POP_FRONT, cdq_pkg::MODE_POP_REAR: begin
          if (empty) begin
            accepted = 1'b0;
          end else begin
            ctl.pop_front = (mode == cdq_pkg::MODE_POP_FRONT);
            ctl.pop_rear  = (mode == cdq_pkg::MODE_POP_REAR);
            count_nxt     = count_r - CNT_W'(1);
          end
        end
        default: begin
          accepted = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // ---------------- cell row ----------------
  logic [VALUE_BITS-1:0] val_q   [MAX_DEPTH];
  logic [VALUE_BITS-1:0] val_nxt [MAX_DEPTH];
  logic [MAX_DEPTH-1:0]  vld_q, vld_nxt;

  for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
    logic [VALUE_BITS-1:0] l_val, r_val;
    logic                  l_vld, r_vld;

    if (i == 0) begin : g_head
      assign l_val = value;
      assign l_vld = 1'b1;
    end else begin : g_mid_l
      assign l_val = val_q[i-1];
      assign l_vld = vld_q[i-1];
    end

    if (i == MAX_DEPTH - 1) begin : g_tail
      assign r_val = '0;
      assign r_vld = 1'b0;
    end else begin : g_mid_r
      assign r_val = val_q[i+1];
      assign r_vld = vld_q[i+1];
    end

    cdq_cell #(
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .push_val  (value),
      .left_val  (l_val),
      .left_vld  (l_vld),
      .right_val (r_val),
      .right_vld (r_vld),
      .val_o     (val_q[i]),
      .vld_o     (vld_q[i]),
      .val_nxt_o (val_nxt[i]),
      .vld_nxt_o (vld_nxt[i])
    );
  end

  // ---------------- result ----------------
  logic [MAX_DEPTH-1:0]  last_sel;
  logic [VALUE_BITS-1:0] front_nxt, rear_nxt;
  logic                  is_empty_nxt, is_full_nxt;
  logic [OUT_W-1:0]      out_data_nxt;
  logic [OUT_W-1:0]      out_data_r;
  logic                  out_valid_r;

  // occupied cells form a prefix; the rear is the last occupied one
  assign last_sel = vld_nxt & ~(vld_nxt >> 1);

  always_comb begin
    rear_nxt = '0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      rear_nxt = rear_nxt | ({VALUE_BITS{last_sel[i]}} & val_nxt[i]);
    end
    if (!vld_nxt[0]) begin
      rear_nxt = '1;
    end
  end

  assign front_nxt    = vld_nxt[0] ? val_nxt[0] : '1;
  assign is_empty_nxt = !vld_nxt[0];
  assign is_full_nxt  = (CW'(count_nxt) == cap_eff);
  assign out_data_nxt = OUT_W'({is_full_nxt, is_empty_nxt, rear_nxt, front_nxt, accepted});

  assign in_tready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------- assertions ----------------
  `CDQ_ASSERT_NOW(a_count_in_range, CW'(count_r) <= cap_eff, "item count above capacity")
  `CDQ_ASSERT_NOW(a_cells_prefix, ((vld_q >> 1) & ~vld_q) == '0, "occupied cells not a prefix")
  `CDQ_ASSERT_NOW(a_count_matches, $countones(vld_q) == int'(count_r), "count disagrees with cells")
  `CDQ_ASSERT_NEXT(a_full_push_refused,
    in_fire && full && (mode == cdq_pkg::MODE_PUSH_FRONT || mode == cdq_pkg::MODE_PUSH_REAR),
    out_tdata[0] == 1'b0, "push to full deque reported as accepted")
  `CDQ_ASSERT_NEXT(a_cfg_empties, cfg_wr, count_r == '0 && vld_q == '0,
    "capacity write did not empty deque")

endmodule

>>> verif/deque_checker.sv
// Checker for the circular deque: mirrors the deque, predicts each result item, compares.
`timescale 1ns / 1ps

module deque_checker #(
  parameter int IN_W  = 40,
  parameter int OUT_W = 72
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [IN_W-1:0]                in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [OUT_W-1:0]               out_tdata,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [cdq_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [cdq_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  input  logic                           cfg_pready,
  output int                             fail_count,
  output int                             pending_results
);
  import cdq_pkg::*;

  localparam int VALUE_W     = DEF_VALUE_BITS;
  localparam int PRINT_LIMIT = 100;

  // Result item layout, lowest bit first: accepted, front, rear, empty, full.
  typedef struct packed {
    logic                      is_full;
    logic                      is_empty;
    logic signed [VALUE_W-1:0] rear_value;
    logic signed [VALUE_W-1:0] front_value;
    logic                      accepted;
  } deque_result_t;

  logic signed [VALUE_W-1:0] held_values[$];     // deque contents, front first
  deque_result_t             expected_results[$];
  int unsigned               capacity_now;
  int                        errors = 0;
  int                        result_idx = 0;

  function automatic int unsigned clip_capacity(logic [CFG_DATA_W-1:0] raw);
    int unsigned c;
    c = raw[CAP_BITS-1:0];
    if (c == 0) c = 1;
    if (c > DEF_MAX_DEPTH) c = DEF_MAX_DEPTH;
    return c;
  endfunction

  function automatic deque_result_t apply_op(logic [MODE_BITS-1:0] mode,
                                             logic signed [VALUE_W-1:0] value);
    deque_result_t res;
    res.accepted = 1'b1;
    case (mode)
      MODE_PUSH_FRONT: begin
        if (held_values.size() >= capacity_now) res.accepted = 1'b0;
        else held_values.push_front(value);
      end
      MODE_PUSH_REAR: begin
        if (held_values.size() >= capacity_now) res.accepted = 1'b0;
        else held_values.push_back(value);
      end
      MODE_POP_FRONT: begin
        if (held_values.size() == 0) res.accepted = 1'b0;
        else void'(held_values.pop_front());
      end
      MODE_POP_REAR: begin
        if (held_values.size() == 0) res.accepted = 1'b0;
        else void'(held_values.pop_back());
      end
      default: ;  // none and undefined modes change nothing
    endcase
    res.is_empty = (held_values.size() == 0);
    res.is_full  = (held_values.size() == capacity_now);
    if (res.is_empty) begin
      res.front_value = '1;
      res.rear_value  = '1;
    end else begin
      res.front_value = held_values[0];
      res.rear_value  = held_values[$];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [VALUE_W-1:0] got,
                                 logic [VALUE_W-1:0] want);
    errors++;
    if (errors <= PRINT_LIMIT)
      $display("[%0t] result %0d: %s got %0h expected %0h", $time, result_idx, what,
               got, want);
  endtask

  always @(posedge clk) begin : watch
    deque_result_t got;
    deque_result_t want;
    if (!rst_n) begin
      held_values.delete();
      expected_results.delete();
      capacity_now = clip_capacity(CAP_RESET);
    end else begin
      // Results first: a result never belongs to an item taken at the same edge.
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(deque_result_t)-1:0];
        result_idx++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result item", '0, '0);
        end else begin
          want = expected_results.pop_front();
          if (got.accepted !== want.accepted)
            report_mismatch("accepted", got.accepted, want.accepted);
          if (got.front_value !== want.front_value)
            report_mismatch("front_value", got.front_value, want.front_value);
          if (got.rear_value !== want.rear_value)
            report_mismatch("rear_value", got.rear_value, want.rear_value);
          if (got.is_empty !== want.is_empty)
            report_mismatch("is_empty", got.is_empty, want.is_empty);
          if (got.is_full !== want.is_full)
            report_mismatch("is_full", got.is_full, want.is_full);
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == REG_CAPACITY) begin
        capacity_now = clip_capacity(cfg_pwdata);
        held_values.delete();
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(apply_op(in_tdata[MODE_BITS-1:0],
                                            in_tdata[MODE_BITS +: VALUE_W]));
    end
    pending_results <= expected_results.size();
    fail_count      <= errors;
  end

endmodule

>>> verif/tb_top.sv
// Testbench top for the circular deque: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import cdq_pkg::*;

  // in_tdata: mode[2:0], value[34:3], pad to 40 bits.
  // out_tdata: accepted, front[32:1], rear[64:33], empty[65], full[66], pad to 72.
  localparam int IN_W         = 40;
  localparam int OUT_W        = 72;
  localparam int VALUE_W      = DEF_VALUE_BITS;
  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 11;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int TAIL_CYCLES  = 8;       // the result output is registered
  localparam int SEG_ITEMS    = 130;     // 3 idle phases x 4 settings x 130 ~ 1600

  localparam logic signed [VALUE_W-1:0] VAL_MIN   = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VAL_MAX   = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VAL_ONES  = '1;
  localparam logic signed [VALUE_W-1:0] VAL_ZERO  = '0;
  localparam logic signed [VALUE_W-1:0] VAL_CHECK = 32'h5a5a_c3c3;

  // Capacity writes; zero and anything above the ring size get clipped by the block.
  localparam logic [CFG_DATA_W-1:0] CAP_MIN      = 1;
  localparam logic [CFG_DATA_W-1:0] CAP_MAX      = DEF_MAX_DEPTH;
  localparam logic [CFG_DATA_W-1:0] CAP_ZERO     = 0;
  localparam logic [CFG_DATA_W-1:0] CAP_OVER     = DEF_MAX_DEPTH + 1;
  localparam logic [CFG_DATA_W-1:0] CAP_FIELD_TOP = (1 << CAP_BITS) - 1;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata    = '0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_W-1:0]      out_tdata;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = REG_CAPACITY;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int fail_count;
  int pending_results;
  int send_idle_pct = 21;
  int recv_idle_pct = 61;
  int cycle_count   = 0;

  always #(CLK_HALF) clk = ~clk;

  circular_deque_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  deque_checker #(.IN_W(IN_W), .OUT_W(OUT_W)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_pready     (cfg_pready),
    .fail_count     (fail_count),
    .pending_results(pending_results)
  );

  // Receiver: random back-pressure at the current phase's rate.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offer one item, with random idle cycles ahead of it; returns at the edge
  // where it is taken. in_tvalid stays high so back-to-back items need no toggle.
  task automatic send_item(input logic [MODE_BITS-1:0] mode,
                           input logic signed [VALUE_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W-MODE_BITS-VALUE_W){1'b0}}, value, mode};
    do @(posedge clk); while (!in_tready);
  endtask

  // Hold the sender until every predicted result has come back. The first
  // edge lets the checker's count catch up with the last item taken.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  // Capacity write: setup then access phase, only with the deque idle.
  task automatic write_capacity(input logic [CFG_DATA_W-1:0] cap);
    wait_drained();
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= REG_CAPACITY;
    cfg_pwdata  <= cap;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly random words, with the corner values mixed in.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(15))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return VAL_ONES;  // same as the empty marker
      3:       return VAL_ZERO;
      default: return $urandom;
    endcase
  endfunction

  // push_pct steers the fill level: high drives toward full, low toward empty.
  function automatic logic [MODE_BITS-1:0] pick_mode(int push_pct);
    int k;
    if ($urandom_range(99) < 5) begin
      k = $urandom_range(3);
      if (k == 0) return MODE_NONE;
      return MODE_POP_REAR + MODE_BITS'(k);  // undefined codes act as none
    end
    if ($urandom_range(99) < push_pct)
      return $urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_REAR;
    return $urandom_range(1) ? MODE_POP_FRONT : MODE_POP_REAR;
  endfunction

  // Random traffic in runs of 32 with a fixed fill bias; one full drain midway.
  task automatic run_segment(input int n_items);
    int push_pct;
    push_pct = 50;
    for (int i = 0; i < n_items; i++) begin
      if (i % 32 == 0) begin
        case ($urandom_range(2))
          0:       push_pct = 15;
          1:       push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      if (i == n_items / 2) wait_drained();
      send_item(pick_mode(push_pct), pick_value());
    end
  endtask

  // Directed corners: empty pops, none/undefined modes, value extremes at
  // both ends, single-entry deque, and clipped capacity writes.
  task automatic directed_items();
    send_item(MODE_POP_FRONT, VAL_ZERO);  // refused: empty
    send_item(MODE_POP_REAR, VAL_ONES);   // refused: empty
    send_item(MODE_NONE, VAL_MAX);
    send_item(MODE_POP_REAR + MODE_BITS'(1), VAL_MIN);
    send_item(MODE_POP_REAR + MODE_BITS'(2), VAL_CHECK);
    send_item(MODE_POP_REAR + MODE_BITS'(3), VAL_ONES);
    send_item(MODE_PUSH_FRONT, VAL_MIN);
    send_item(MODE_PUSH_REAR, VAL_MAX);
    send_item(MODE_PUSH_FRONT, VAL_ONES);
    send_item(MODE_PUSH_REAR, VAL_ZERO);
    send_item(MODE_POP_FRONT, VAL_ZERO);
    send_item(MODE_POP_REAR, VAL_ZERO);
    send_item(MODE_POP_FRONT, VAL_ZERO);
    send_item(MODE_POP_REAR, VAL_ZERO);
    send_item(MODE_POP_FRONT, VAL_ZERO);  // refused: empty again
    // One-entry deque: full after a single push.
    write_capacity(CAP_MIN);
    send_item(MODE_PUSH_REAR, VAL_CHECK);
    send_item(MODE_PUSH_FRONT, VAL_MAX);  // refused: full
    send_item(MODE_POP_FRONT, VAL_ZERO);
    send_item(MODE_POP_REAR, VAL_ZERO);   // refused: empty
    // Zero capacity behaves as one.
    write_capacity(CAP_ZERO);
    send_item(MODE_PUSH_FRONT, VAL_MIN);
    send_item(MODE_PUSH_REAR, VAL_MIN);   // refused: full
    // Oversized capacities clip to the ring size.
    write_capacity(CAP_FIELD_TOP);
    send_item(MODE_PUSH_REAR, VAL_CHECK);
    write_capacity(CAP_OVER);
    send_item(MODE_PUSH_FRONT, VAL_CHECK);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset capacity is the full ring; directed items run on it first.
    directed_items();

    // Three idle profiles: sender lighter, then receiver lighter, then none.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 21;
          recv_idle_pct = 61;
        end
        1: begin
          send_idle_pct = 61;
          recv_idle_pct = 21;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        case (seg)
          0:       write_capacity(CAP_MAX);
          1:       write_capacity($urandom_range(1, 4));   // small rings fill often
          2:       write_capacity($urandom_range(0, CAP_FIELD_TOP));
          default: write_capacity($urandom_range(5, DEF_MAX_DEPTH));
        endcase
        run_segment(SEG_ITEMS);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
